### rtl/kan_bspline_activation_defines.svh
// assertion macros used by the checker file
`ifndef KAN_BSPLINE_ACTIVATION_DEFINES_SVH
`define KAN_BSPLINE_ACTIVATION_DEFINES_SVH

// same-cycle implication, disabled during reset
`define KBA_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define KBA_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/kba_pkg.sv
// shared constants for the b-spline activation block
`default_nettype none
package kba_pkg;
  localparam int MAX_INTERVALS_DEF = 16;
  localparam int MAX_ORDER_DEF     = 4;
  localparam int FRAC_BITS         = 30;
  localparam logic [30:0] ONE_Q30  = 31'h4000_0000;

  // func codes
  localparam logic [1:0] FUNC_KNOT   = 2'd0;
  localparam logic [1:0] FUNC_WEIGHT = 2'd1;
  localparam logic [1:0] FUNC_EVAL   = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_ORDER     = 2'd0;
  localparam logic [1:0] CFG_INTERVALS = 2'd1;
  localparam logic [1:0] CFG_BASE      = 2'd2;
endpackage
`default_nettype wire

### rtl/kba_ram.sv
// generic single-port-write ram with registered read
`default_nettype none
module kba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH > 1 ? DEPTH : 2)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/kan_bspline_activation.sv
// Evaluation steps: degree-0 indicators, then per higher degree two terms per basis, each a
// product with a divide when needed, then a weighted sum plus the base term; n = g+2k-1.
// The 30-step shared divider dominates. One evaluate word at a time.
// Knot and weight loads leave the block ready; a new word is taken only after a result is issued.
// Reset (synchronous): registers to order 4, 8 intervals, base weight 0; tables
// are not cleared.
`default_nettype none
module kan_bspline_activation
  import kba_pkg::*;
#(
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
  parameter int MAX_ORDER     = MAX_ORDER_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         func,
  input  wire logic [4:0]         load_index,
  input  wire logic signed [31:0] load_value,
  input  wire logic signed [31:0] sample,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      activation,
  output logic                    saturated
);
  localparam int KNOT_DEPTH   = MAX_INTERVALS + 1;
  localparam int WEIGHT_DEPTH = MAX_INTERVALS + MAX_ORDER - 1;
  localparam int EXT_DEPTH    = MAX_INTERVALS + 2 * MAX_ORDER - 1;
  localparam int KA_W = $clog2(KNOT_DEPTH > 1 ? KNOT_DEPTH : 2);
  localparam int WA_W = $clog2(WEIGHT_DEPTH > 1 ? WEIGHT_DEPTH : 2);
  localparam int BA_W = $clog2(EXT_DEPTH > 1 ? EXT_DEPTH : 2);
  localparam int IW   = $clog2(EXT_DEPTH + 2);
  localparam int CW   = $clog2(FRAC_BITS + 1);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_E0     = 5'd1;
  localparam logic [4:0] ST_E1     = 5'd2;
  localparam logic [4:0] ST_E2     = 5'd3;
  localparam logic [4:0] ST_DI0    = 5'd4;
  localparam logic [4:0] ST_DI1    = 5'd5;
  localparam logic [4:0] ST_DI2    = 5'd6;
  localparam logic [4:0] ST_DF0    = 5'd7;
  localparam logic [4:0] ST_DF1    = 5'd8;
  localparam logic [4:0] ST_DF2    = 5'd9;
  localparam logic [4:0] ST_TERM   = 5'd10;
  localparam logic [4:0] ST_DIV    = 5'd11;
  localparam logic [4:0] ST_MUL    = 5'd12;
  localparam logic [4:0] ST_MACC   = 5'd13;
  localparam logic [4:0] ST_TNEXT  = 5'd14;
  localparam logic [4:0] ST_WB     = 5'd15;
  localparam logic [4:0] ST_FINIT  = 5'd16;
  localparam logic [4:0] ST_FRD    = 5'd17;
  localparam logic [4:0] ST_FMUL   = 5'd18;
  localparam logic [4:0] ST_FACC   = 5'd19;
  localparam logic [4:0] ST_FBASE  = 5'd20;
  localparam logic [4:0] ST_FBACC  = 5'd21;
  localparam logic [4:0] ST_DONE   = 5'd22;

  // configuration registers
  logic [2:0]         spline_order;
  logic [4:0]         intervals_in_use;
  logic signed [31:0] base_weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      spline_order     <= 3'd4;
      intervals_in_use <= 5'd8;
      base_weight      <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ORDER:     spline_order     <= cfg_data[2:0];
        CFG_INTERVALS: intervals_in_use <= cfg_data[4:0];
        CFG_BASE:      base_weight      <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped order, interval count and extended length
  logic [31:0]   so32, gi32, k32, g32, n32;
  logic [IW-1:0] k_eff, g_eff, n_len, km1;

  always_comb begin
    so32 = {29'b0, spline_order};
    gi32 = {27'b0, intervals_in_use};
    k32  = (so32 == 0) ? 32'd1 : (so32 > MAX_ORDER) ? MAX_ORDER : so32;
    g32  = (gi32 == 0) ? 32'd1 : (gi32 > MAX_INTERVALS) ? MAX_INTERVALS : gi32;
    n32  = g32 + 2 * k32 - 1;
    k_eff = k32[IW-1:0];
    g_eff = g32[IW-1:0];
    n_len = n32[IW-1:0];
    km1   = k_eff - 1'b1;
  end

  // knot table address for an extended index
  function automatic logic [KA_W-1:0] ext_addr(input logic [IW-1:0] j,
                                               input logic [IW-1:0] kk,
                                               input logic [IW-1:0] gg);
    logic [IW-1:0] t;
    logic [IW-1:0] pick;
    t = j - kk;
    if (j < kk) pick = '0;
    else if (t <= gg) pick = t;
    else pick = gg;
    return pick[KA_W-1:0];
  endfunction

  logic [4:0]         state;
  logic [IW-1:0]      i, d;
  logic               term;
  logic signed [31:0] x, klo, khi, kd, kdhi;
  logic [30:0]        blo, bhi, ratio;
  logic [31:0]        s;
  logic signed [63:0] acc;
  logic signed [65:0] prod;
  logic [33:0]        rem;
  logic [32:0]        dden;
  logic [FRAC_BITS-1:0] q;
  logic [CW-1:0]      cnt;

  // memories
  logic               k_we, w_we, b_we;
  logic [KA_W-1:0]    k_waddr, k_raddr;
  logic [WA_W-1:0]    w_waddr, w_raddr;
  logic [BA_W-1:0]    b_waddr, b_raddr;
  logic [30:0]        b_wdata, b_rdata;
  logic [31:0]        k_rdata, w_rdata;
  logic [31:0]        li32;
  logic [IW-1:0]      jsel, bsel;
  logic               accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign li32     = {27'b0, load_index};
  assign k_we     = accept && (func == FUNC_KNOT) && (li32 < KNOT_DEPTH);
  assign w_we     = accept && (func == FUNC_WEIGHT) && (li32 < WEIGHT_DEPTH);
  assign k_waddr  = li32[KA_W-1:0];
  assign w_waddr  = li32[WA_W-1:0];
  assign w_raddr  = i[WA_W-1:0];

  // read address selection by step
  always_comb begin
    case (state)
      ST_E1:   jsel = {{(IW-1){1'b0}}, 1'b1};
      ST_E2:   jsel = i + 2'd2;
      ST_DI1:  jsel = d;
      ST_DF0:  jsel = i + 1'b1;
      ST_DF1:  jsel = i + d + 1'b1;
      default: jsel = '0;
    endcase
    case (state)
      ST_DF0:  bsel = i + 1'b1;
      ST_FRD:  bsel = i;
      default: bsel = '0;
    endcase
    k_raddr = ext_addr(jsel, km1, g_eff);
    b_raddr = bsel[BA_W-1:0];
  end

  // degree-0 indicator
  logic ind;
  assign ind = (x >= klo) && (x < $signed(k_rdata));

  // basis writes
  always_comb begin
    b_waddr = i[BA_W-1:0];
    b_we    = (state == ST_E2) || (state == ST_WB);
    if (state == ST_E2) b_wdata = ind ? ONE_Q30 : '0;
    else b_wdata = (s > {1'b0, ONE_Q30}) ? ONE_Q30 : s[30:0];
  end

  // current term operands
  logic [30:0]        b_sel;
  logic signed [32:0] t_num, t_den;
  logic               t_skip, t_full;

  always_comb begin
    b_sel = term ? bhi : blo;
    t_num = term ? ({kdhi[31], kdhi} - {x[31], x}) : ({x[31], x} - {klo[31], klo});
    t_den = term ? ({kdhi[31], kdhi} - {khi[31], khi}) : ({kd[31], kd} - {klo[31], klo});
    t_skip = (b_sel == '0) || (t_den <= 0) || (t_num <= 0);
    t_full = (t_num >= t_den);
  end

  // restoring divider step
  logic [33:0] rem2;
  logic        ge;
  logic [FRAC_BITS-1:0] q_new;
  always_comb begin
    rem2  = {rem[32:0], 1'b0};
    ge    = rem2 >= {1'b0, dden};
    q_new = {q[FRAC_BITS-2:0], ge};
  end

  // shared multiplier operands
  logic signed [32:0] mul_a, mul_b;
  always_comb begin
    case (state)
      ST_FMUL: begin
        mul_a = $signed({2'b0, b_rdata});
        mul_b = $signed({w_rdata[31], w_rdata});
      end
      ST_FBASE: begin
        mul_a = $signed({base_weight[31], base_weight});
        mul_b = $signed({x[31], x});
      end
      default: begin
        mul_a = $signed({2'b0, ratio});
        mul_b = $signed({2'b0, b_sel});
      end
    endcase
  end

  // final truncation and saturation
  logic [47:0] tot;
  logic        sat_hi, sat_lo;
  assign tot    = acc[63:16];
  assign sat_hi = !tot[47] && (|tot[46:31]);
  assign sat_lo = tot[47] && !(&tot[46:31]);

  logic [IW-1:0] d0_last, dd_last, f_last;
  assign d0_last = n_len - 2'd2;
  assign dd_last = n_len - 2'd2 - d;
  assign f_last  = n_len - k_eff - 1'b1;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_DONE) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept && func == FUNC_EVAL) begin
            x     <= sample;
            state <= ST_E0;
          end
        end
        ST_E0: state <= ST_E1;
        ST_E1: begin
          klo   <= $signed(k_rdata);
          i     <= '0;
          state <= ST_E2;
        end
        ST_E2: begin
          klo <= $signed(k_rdata);
          if (i == d0_last) begin
            d     <= {{(IW-1){1'b0}}, 1'b1};
            state <= (k_eff > 1) ? ST_DI0 : ST_FINIT;
          end else begin
            i <= i + 1'b1;
          end
        end
        ST_DI0: begin
          i     <= '0;
          state <= ST_DI1;
        end
        ST_DI1: begin
          klo   <= $signed(k_rdata);
          blo   <= b_rdata;
          state <= ST_DI2;
        end
        ST_DI2: begin
          kd    <= $signed(k_rdata);
          state <= ST_DF0;
        end
        ST_DF0: state <= ST_DF1;
        ST_DF1: begin
          khi   <= $signed(k_rdata);
          bhi   <= b_rdata;
          state <= ST_DF2;
        end
        ST_DF2: begin
          kdhi  <= $signed(k_rdata);
          term  <= 1'b0;
          s     <= '0;
          state <= ST_TERM;
        end
        ST_TERM: begin
          if (t_skip) begin
            state <= ST_TNEXT;
          end else if (t_full) begin
            ratio <= ONE_Q30;
            state <= ST_MUL;
          end else begin
            rem   <= {1'b0, t_num};
            dden  <= t_den;
            q     <= '0;
            cnt   <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem <= ge ? (rem2 - {1'b0, dden}) : rem2;
          q   <= q_new;
          cnt <= cnt + 1'b1;
          if (cnt == CW'(FRAC_BITS - 1)) begin
            ratio <= {1'b0, q_new};
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= mul_a * mul_b;
          state <= ST_MACC;
        end
        ST_MACC: begin
          s     <= s + {1'b0, prod[60:30]};
          state <= ST_TNEXT;
        end
        ST_TNEXT: begin
          if (!term) begin
            term  <= 1'b1;
            state <= ST_TERM;
          end else begin
            state <= ST_WB;
          end
        end
        ST_WB: begin
          if (i == dd_last) begin
            d     <= d + 1'b1;
            state <= (d + 1'b1 < k_eff) ? ST_DI0 : ST_FINIT;
          end else begin
            klo   <= khi;
            kd    <= kdhi;
            blo   <= bhi;
            i     <= i + 1'b1;
            state <= ST_DF0;
          end
        end
        ST_FINIT: begin
          acc   <= '0;
          i     <= '0;
          state <= ST_FRD;
        end
        ST_FRD: state <= ST_FMUL;
        ST_FMUL: begin
          prod  <= mul_a * mul_b;
          state <= ST_FACC;
        end
        ST_FACC: begin
          acc <= acc + {{12{prod[65]}}, prod[65:14]};
          if (i == f_last) begin
            state <= ST_FBASE;
          end else begin
            i     <= i + 1'b1;
            state <= ST_FRD;
          end
        end
        ST_FBASE: begin
          prod  <= mul_a * mul_b;
          state <= ST_FBACC;
        end
        ST_FBACC: begin
          acc   <= acc + prod[63:0];
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            saturated  <= sat_hi || sat_lo;
            activation <= sat_hi ? 32'sh7fff_ffff : sat_lo ? 32'sh8000_0000
                                 : $signed(tot[31:0]);
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  kba_ram #(.WIDTH(32), .DEPTH(KNOT_DEPTH)) u_knots (
    .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(load_value),
    .raddr(k_raddr), .rdata(k_rdata)
  );

  kba_ram #(.WIDTH(32), .DEPTH(WEIGHT_DEPTH)) u_weights (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(load_value),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  kba_ram #(.WIDTH(31), .DEPTH(EXT_DEPTH)) u_basis (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );
endmodule
`default_nettype wire

### rtl/kba_checker.sv
// port-level checks for the b-spline activation block, bound to the top level
`default_nettype none
`include "kan_bspline_activation_defines.svh"
module kba_checker
  import kba_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  func,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] activation,
  input wire logic        saturated
);
  // a stalled result word holds
  `KBA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(activation) && $stable(saturated), "result changed while stalled")
  // evaluate makes the block busy
  `KBA_ASSERT_NEXT(a_eval_busy, in_valid && in_ready && func == FUNC_EVAL, !in_ready, "ready after evaluate")
  // loads and unused codes finish at once
  `KBA_ASSERT_NEXT(a_load_fast, in_valid && in_ready && func != FUNC_EVAL, in_ready, "busy after load")
  // clipping gives a range bound
  `KBA_ASSERT_NOW(a_sat_bound, out_valid && saturated, activation == 32'h7fff_ffff || activation == 32'h8000_0000, "saturated word not at bound")
endmodule

bind kan_bspline_activation kba_checker u_chk (.*);
`default_nettype wire
